/* rtl/msk_pkg.sv */
// ----------------------------------------------------------------------------
// msk_pkg
// Shared types, constants and helpers for the 4x4 matrix stack block.
// ----------------------------------------------------------------------------
package msk_pkg;

  // Configuration of the stack array
  localparam int NUM_STACKS  = 4;
  localparam int STACK_DEPTH = 16;

  // Derived widths
  localparam int STACK_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int LEVEL_W = $clog2(STACK_DEPTH);
  localparam int ELEM_W  = 4;
  localparam int ADDR_W  = STACK_W + LEVEL_W + ELEM_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // Four Q32.32 products summed exactly
  localparam int ACC_W = 66;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  typedef enum logic [2:0] {
    CMD_LOAD  = 3'd0,
    CMD_IDENT = 3'd1,
    CMD_PUSH  = 3'd2,
    CMD_POP   = 3'd3,
    CMD_CLEAR = 3'd4,
    CMD_MUL   = 3'd5,
    CMD_GET   = 3'd6
  } msk_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } msk_status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_PUSH_RD,
    S_PUSH_WB,
    S_MUL_RD,
    S_MUL_WAIT,
    S_MUL_WB,
    S_MUL_LAST,
    S_GET_RD,
    S_GET_WAIT,
    S_DONE
  } msk_state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [1:0]         stack_id;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
  } msk_in_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [3:0]         out_index;
    logic               last;
    logic [1:0]         status;
  } msk_out_t;

  // Controls from the sequencer to the multiply unit
  typedef struct packed {
    logic        ob_we;     // store one operand element
    logic [3:0]  ob_idx;
    logic        rd_issue;  // top element read issued this cycle
    logic [3:0]  rd_elem;
    logic        acc_clr;   // start of a product
    logic        wb_rot;    // step the result lines during write back
    logic [1:0]  wb_col;
  } msk_mac_ctl_t;

  // Identity element: diagonal when row == column
  function automatic logic [31:0] ident_word(input logic [3:0] e);
    return (e[1:0] == e[3:2]) ? ONE_Q16 : 32'h0;
  endfunction

endpackage

/* rtl/msk_ram.sv */
// ----------------------------------------------------------------------------
// msk_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module msk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/msk_mac.sv */
// ----------------------------------------------------------------------------
// msk_mac
// Four multiply-accumulate lanes, one per result column. Each top element
// streamed from the store is multiplied by the operand element of every
// column; per lane a four-entry rotating line holds the row sums. Write back
// rotates the lines and saturates the selected sum to Q16.16.
// ----------------------------------------------------------------------------
module msk_mac (
  input  logic                  clk,
  input  logic                  rst_n,
  input  msk_pkg::msk_mac_ctl_t ctl,
  input  logic [31:0]           op_value,
  input  logic [31:0]           a_data,
  output logic                  busy,
  output logic [31:0]           wb_word
);
  import msk_pkg::*;

  logic signed [31:0]      ob_r [16];
  logic                    rd_pend_r;
  logic [1:0]              rd_k_r;
  logic                    p_pend_r;
  logic signed [63:0]      prod_r [4];
  logic signed [ACC_W-1:0] line_r [4][4];
  logic [31:0]             wb_word_r;

  logic signed [31:0]      a_s;
  logic signed [63:0]      prod_c [4];
  logic signed [ACC_W-1:0] head_sel;
  logic [31:0]             sat_word;

  // Products for the four columns
  always_comb begin
    a_s = a_data;
    for (int c = 0; c < 4; c++) begin
      prod_c[c] = a_s * ob_r[{2'(c), rd_k_r}];
    end
  end

  // Saturate floor(sum / 2^16) into 32 bits
  always_comb begin
    head_sel = line_r[ctl.wb_col][0];
    if (head_sel[ACC_W-1:47] == '0 || head_sel[ACC_W-1:47] == '1) begin
      sat_word = head_sel[47:16];
    end else if (head_sel[ACC_W-1]) begin
      sat_word = 32'h8000_0000;
    end else begin
      sat_word = 32'h7FFF_FFFF;
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      p_pend_r  <= 1'b0;
    end else begin
      rd_pend_r <= ctl.rd_issue;
      p_pend_r  <= rd_pend_r;
    end
  end

  // Operand buffer, products, row sums and write back word
  always_ff @(posedge clk) begin
    if (ctl.ob_we) begin
      ob_r[ctl.ob_idx] <= op_value;
    end
    rd_k_r <= ctl.rd_elem[3:2];
    for (int c = 0; c < 4; c++) begin
      prod_r[c] <= prod_c[c];
    end
    for (int c = 0; c < 4; c++) begin
      if (ctl.acc_clr) begin
        for (int r = 0; r < 4; r++) begin
          line_r[c][r] <= '0;
        end
      end else if (p_pend_r) begin
        line_r[c][0] <= line_r[c][1];
        line_r[c][1] <= line_r[c][2];
        line_r[c][2] <= line_r[c][3];
        line_r[c][3] <= line_r[c][0] + ACC_W'(prod_r[c]);
      end else if (ctl.wb_rot) begin
        line_r[c][0] <= line_r[c][1];
        line_r[c][1] <= line_r[c][2];
        line_r[c][2] <= line_r[c][3];
        line_r[c][3] <= line_r[c][0];
      end
    end
    wb_word_r <= sat_word;
  end

  assign busy    = rd_pend_r | p_pend_r;
  assign wb_word = wb_word_r;

endmodule

/* rtl/msk_ctrl.sv */
// ----------------------------------------------------------------------------
// msk_ctrl
// Command sequencer: stack levels, matrix store addressing, push copy,
// multiply streaming and write back, get read out and the output register.
// ----------------------------------------------------------------------------
module msk_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  msk_pkg::msk_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output msk_pkg::msk_out_t            out_data,
  output logic                         ram_we,
  output logic [msk_pkg::ADDR_W-1:0]   ram_waddr,
  output logic [31:0]                  ram_wdata,
  output logic [msk_pkg::ADDR_W-1:0]   ram_raddr,
  input  logic [31:0]                  ram_rdata,
  output msk_pkg::msk_mac_ctl_t        mac_ctl,
  output logic [31:0]                  mac_op_value,
  input  logic                         mac_busy,
  input  logic [31:0]                  mac_wb_word
);
  import msk_pkg::*;

  msk_state_t         state_r, state_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [STACK_W-1:0] clr_stack_r, clr_stack_nxt;
  logic [LEVEL_W-1:0] lvl_r [NUM_STACKS];
  logic [LEVEL_W-1:0] lvl_nxt [NUM_STACKS];
  msk_in_t            item_r, item_nxt;
  msk_status_t        status_r, status_nxt;
  logic               cp_pend_r, cp_pend_nxt;
  logic [3:0]         cp_elem_r, cp_elem_nxt;
  logic               get_pend_r, get_pend_nxt;
  logic [3:0]         get_elem_r, get_elem_nxt;
  logic               wb_pend_r, wb_pend_nxt;
  logic [3:0]         wb_elem_r, wb_elem_nxt;
  logic               out_valid_r, out_valid_nxt;
  msk_out_t           out_data_r, out_data_nxt;

  logic [STACK_W-1:0] sid;
  logic [LEVEL_W-1:0] lvl_cur;
  logic [LEVEL_W-1:0] lvl_up;
  logic               in_range;
  logic               out_free;
  logic               out_load;
  msk_out_t           out_word;

  assign sid      = STACK_W'(item_r.stack_id);
  assign lvl_cur  = lvl_r[sid];
  assign lvl_up   = lvl_cur + 1'b1;
  assign in_range = ({3'b000, item_r.stack_id} < 5'(NUM_STACKS));
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // Operand element of the held transaction
  assign mac_op_value = item_r.element_value;

  // Next state, store accesses and result generation
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_stack_nxt = clr_stack_r;
    lvl_nxt       = lvl_r;
    item_nxt      = item_r;
    status_nxt    = status_r;
    cp_pend_nxt   = 1'b0;
    cp_elem_nxt   = cnt_r;
    get_pend_nxt  = 1'b0;
    get_elem_nxt  = get_elem_r;
    wb_pend_nxt   = 1'b0;
    wb_elem_nxt   = cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = {sid, lvl_cur, cnt_r};
    ram_wdata     = ident_word(cnt_r);
    ram_raddr     = {sid, lvl_cur, cnt_r};
    mac_ctl       = '0;
    mac_ctl.ob_idx  = item_r.element_index;
    mac_ctl.rd_elem = cnt_r;
    mac_ctl.wb_col  = cnt_r[3:2];
    out_load      = 1'b0;
    out_word      = '0;

    case (state_r)
      // Identity into the bottom level of every stack
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = {clr_stack_r, LEVEL_W'(0), cnt_r};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == 4'hF) begin
          clr_stack_nxt = clr_stack_r + 1'b1;
          if (clr_stack_r == STACK_W'(NUM_STACKS - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        status_nxt = ST_OK;
        cnt_nxt    = 4'h0;
        state_nxt  = S_DONE;
        if (in_range) begin
          case (msk_cmd_t'(item_r.command))
            CMD_LOAD: begin
              ram_we    = 1'b1;
              ram_waddr = {sid, lvl_cur, item_r.element_index};
              ram_wdata = item_r.element_value;
            end
            CMD_IDENT: begin
              state_nxt = S_FILL;
            end
            CMD_PUSH: begin
              if (lvl_cur == LEVEL_W'(STACK_DEPTH - 1)) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_PUSH_RD;
              end
            end
            CMD_POP: begin
              if (lvl_cur == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                lvl_nxt[sid] = lvl_cur - 1'b1;
              end
            end
            CMD_CLEAR: begin
              lvl_nxt[sid] = '0;
              state_nxt    = S_FILL;
            end
            CMD_MUL: begin
              mac_ctl.ob_we = 1'b1;
              if (item_r.element_index == 4'hF) begin
                mac_ctl.acc_clr = 1'b1;
                state_nxt       = S_MUL_RD;
              end
            end
            CMD_GET: begin
              state_nxt = S_GET_RD;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Identity into the top, one element a cycle
      S_FILL: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'hF) begin
          state_nxt = S_DONE;
        end
      end

      // Read the top; each copy is written one level up in the cycle after its read
      S_PUSH_RD: begin
        cp_pend_nxt = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == 4'hF) begin
          state_nxt = S_PUSH_WB;
        end
      end

      S_PUSH_WB: begin
        lvl_nxt[sid] = lvl_up;
        state_nxt    = S_DONE;
      end

      // Stream the top into the MAC lanes
      S_MUL_RD: begin
        mac_ctl.rd_issue = 1'b1;
        cnt_nxt          = cnt_r + 1'b1;
        if (cnt_r == 4'hF) begin
          state_nxt = S_MUL_WAIT;
        end
      end

      S_MUL_WAIT: begin
        if (!mac_busy) begin
          cnt_nxt   = 4'h0;
          state_nxt = S_MUL_WB;
        end
      end

      // Saturated results back into the top, one a cycle
      S_MUL_WB: begin
        mac_ctl.wb_rot = 1'b1;
        wb_pend_nxt    = 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
        if (cnt_r == 4'hF) begin
          state_nxt = S_MUL_LAST;
        end
      end

      S_MUL_LAST: begin
        state_nxt = S_DONE;
      end

      // One read in flight, issued only when the output slot frees up
      S_GET_RD: begin
        if (!get_pend_r && out_free) begin
          get_pend_nxt = 1'b1;
          get_elem_nxt = cnt_r;
          cnt_nxt      = cnt_r + 1'b1;
          if (cnt_r == 4'hF) begin
            state_nxt = S_GET_WAIT;
          end
        end
      end

      S_GET_WAIT: begin
        if (!get_pend_r) begin
          state_nxt = S_IDLE;
        end
      end

      // Single status transaction
      S_DONE: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_word.last   = 1'b1;
          out_word.status = status_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Delayed writes of the push copy and the multiply results
    if (cp_pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = {sid, lvl_up, cp_elem_r};
      ram_wdata = ram_rdata;
    end
    if (wb_pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = {sid, lvl_cur, wb_elem_r};
      ram_wdata = mac_wb_word;
    end

    // Get data arrives in the cycle after its read
    if (get_pend_r) begin
      out_load           = 1'b1;
      out_word.out_value = ram_rdata;
      out_word.out_index = get_elem_r;
      out_word.last      = (get_elem_r == 4'hF);
      out_word.status    = ST_OK;
    end

    // Output register
    out_valid_nxt = out_load | (out_valid_r & out_stall);
    out_data_nxt  = out_load ? out_word : out_data_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= 4'h0;
      clr_stack_r <= '0;
      cp_pend_r   <= 1'b0;
      get_pend_r  <= 1'b0;
      wb_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < NUM_STACKS; s++) begin
        lvl_r[s] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_stack_r <= clr_stack_nxt;
      cp_pend_r   <= cp_pend_nxt;
      get_pend_r  <= get_pend_nxt;
      wb_pend_r   <= wb_pend_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_r       <= lvl_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    status_r   <= status_nxt;
    cp_elem_r  <= cp_elem_nxt;
    get_elem_r <= get_elem_nxt;
    wb_elem_r  <= wb_elem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/matrix_stack_4x4.sv */
// ----------------------------------------------------------------------------
// matrix_stack_4x4
// Independent stacks of column-major 4x4 Q16.16 matrices held in one
// synchronous store, with load, identity, push, pop, clear, multiply and get.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload   | transactions per command
//  --------+--------------------+-----------+---------------------------------
//  in      | in_valid/in_stall  | msk_in_t  | one
//  out     | out_valid/out_stall| msk_out_t | 16 for get, else one status
//
//  One command at a time; the store has one read and one write port per cycle.
//  Load, pop and refused commands: decode, then status. Identity, clear: 16
//  identity writes. Push: 16 reads, each copy written one level up after its
//  read. Get: one read at a time, each once the last result is loaded and the
//  output slot is free. Multiply on operand element 15: 16 reads into four MAC
//  lanes, pipeline drain, 16 saturated write backs. After reset the bottom
//  level of every stack is written to identity; in_stall stays high meanwhile.
//  A new command is taken while the previous result still waits on out_stall.
// ----------------------------------------------------------------------------
module matrix_stack_4x4 (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  msk_pkg::msk_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output msk_pkg::msk_out_t out_data
);
  import msk_pkg::*;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;
  msk_mac_ctl_t      mac_ctl;
  logic [31:0]       mac_op_value;
  logic              mac_busy;
  logic [31:0]       mac_wb_word;

  // Matrix store
  msk_ram #(
    .WIDTH (32),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Multiply lanes
  msk_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .op_value (mac_op_value),
    .a_data   (ram_rdata),
    .busy     (mac_busy),
    .wb_word  (mac_wb_word)
  );

  // Sequencer
  msk_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .mac_ctl      (mac_ctl),
    .mac_op_value (mac_op_value),
    .mac_busy     (mac_busy),
    .mac_wb_word  (mac_wb_word)
  );

endmodule
